[rtl/ibma_pkg.sv]
// ----------------------------------------------------------------------------
// ibma_pkg
// Shared types, sizes and search helpers for the bitmap id allocator.
// ----------------------------------------------------------------------------
package ibma_pkg;

  localparam int ID_COUNT = 4096;
  localparam int WORD_W   = 64;
  localparam int BIT_W    = $clog2(WORD_W);
  localparam int WORD_CNT = (ID_COUNT + WORD_W - 1) / WORD_W;
  localparam int ADDR_W   = (WORD_CNT > 1) ? $clog2(WORD_CNT) : 1;
  localparam int IDX_W    = ADDR_W + BIT_W;
  // wide enough to hold 65536 and ID_COUNT
  localparam int CNT_W    = 17;

  localparam logic [15:0] BASE_RESET = 16'd300;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_EXHAUSTED = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [15:0] release_id;
  } req_t;

  typedef struct packed {
    logic [15:0] granted_id;
    logic [1:0]  status;
  } rsp_t;

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] wdata;
  } ram_req_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_MOD
  } state_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] idx;
  } word_hit_t;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] idx;
  } bit_hit_t;

  // lowest word whose full flag is clear
  function automatic word_hit_t first_open_word(logic [WORD_CNT-1:0] full);
    word_hit_t r;
    r.found = 1'b0;
    r.idx   = '0;
    for (int i = WORD_CNT - 1; i >= 0; i--) begin
      if (!full[i]) begin
        r.found = 1'b1;
        r.idx   = ADDR_W'(i);
      end
    end
    return r;
  endfunction

  // lowest clear bit of a bitmap word
  function automatic bit_hit_t first_zero_bit(logic [WORD_W-1:0] w);
    bit_hit_t r;
    r.found = 1'b0;
    r.idx   = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) begin
        r.found = 1'b1;
        r.idx   = BIT_W'(i);
      end
    end
    return r;
  endfunction

endpackage

[rtl/id_bitmap_allocator_unit.sv]
// ----------------------------------------------------------------------------
// id_bitmap_allocator_unit
// Allocates and releases identifiers from a bitmap of taken marks.
// ----------------------------------------------------------------------------
// Request channel: a beat (req.mode, req.release_id) is taken at a clock edge
// with start high and busy low. mode 0 grants the lowest free identifier of
// id_base .. min(id_base + ID_COUNT - 1, 65535), mode 1 frees req.release_id.
// Result channel: done is high for one cycle with rsp (granted_id, status);
// the receiver cannot stall, so results are never held back.
// Config channel: cfg_data is written to id_base when cfg_valid is high;
// cfg_ready is always high. Write only while no request is in flight.
// Sequence: a request that reads a mark word keeps busy high through S_LOOK and
// S_MOD and has done as the block returns to S_IDLE, when the next request may
// already be taken. Allocate with no open word and release out of range skip
// the read: busy only through S_LOOK, done as the block returns to S_IDLE. Each
// request reads and writes back at most one 64-bit word; per-word full flags
// pick the word to read, so no scan is needed.
// Reset: all identifiers free and id_base = 300, in the reset cycle itself;
// rows of the mark memory are tracked by valid flags, so no clearing pass.
// ----------------------------------------------------------------------------
module id_bitmap_allocator_unit
  import ibma_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  req_t        req,
  output logic        done,
  output rsp_t        rsp,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic [15:0]       id_base;
  ram_req_t          ram_req;
  logic [WORD_W-1:0] ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      id_base <= BASE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      id_base <= cfg_data;
    end
  end

  ibma_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req),
    .id_base   (id_base),
    .busy      (busy),
    .done      (done),
    .rsp       (rsp),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  ibma_mark_ram u_mark_ram (
    .clk   (clk),
    .rst   (rst),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  // a word is read and written back in different cycles
  a_ram_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ram_req.rd_en && ram_req.wr_en))
    else $error("mark memory read and write in the same cycle");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without a request in flight");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request taken but block not busy");

  a_write_follows_read: assert property (@(posedge clk) disable iff (rst)
    ram_req.wr_en |-> $past(ram_req.rd_en))
    else $error("mark word written without a prior read");

  a_grant_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != STAT_OK) |-> (rsp.granted_id == 16'd0))
    else $error("failed request carries an identifier");

endmodule

[rtl/ibma_mark_ram.sv]
// ----------------------------------------------------------------------------
// ibma_mark_ram
// Taken-mark store: one bitmap word per row, registered read.
// Rows never written since reset read as all free.
// ----------------------------------------------------------------------------
module ibma_mark_ram
  import ibma_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  ram_req_t          req,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0]   mem [WORD_CNT];
  logic [WORD_CNT-1:0] row_valid;
  logic [WORD_W-1:0]   rd_word;
  logic                rd_valid;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rd_word <= mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (req.wr_en) begin
        row_valid[req.addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid <= row_valid[req.addr];
      end
    end
  end

  assign rdata = rd_valid ? rd_word : '0;

endmodule

[rtl/ibma_ctrl.sv]
// ----------------------------------------------------------------------------
// ibma_ctrl
// Request sequencer: word summary search, read-modify-write of one bitmap
// word, result register.
// ----------------------------------------------------------------------------
module ibma_ctrl
  import ibma_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  req_t              req,
  input  logic [15:0]       id_base,
  output logic              busy,
  output logic              done,
  output rsp_t              rsp,
  output ram_req_t          ram_req,
  input  logic [WORD_W-1:0] ram_rdata
);

  state_t              state, state_next;
  logic [WORD_CNT-1:0] full, full_next;
  logic                mode;
  logic [15:0]         release_id;
  logic [ADDR_W-1:0]   word_addr, word_addr_next;
  logic [BIT_W-1:0]    bit_sel, bit_sel_next;
  logic [CNT_W-1:0]    limit, limit_next;
  logic                done_next;
  rsp_t                rsp_next;

  word_hit_t           open_word;
  bit_hit_t            free_bit;
  logic [CNT_W-1:0]    room;
  logic [CNT_W-1:0]    offset;
  logic                in_range;
  logic [IDX_W-1:0]    alloc_idx;
  logic [WORD_W-1:0]   set_word;
  logic [WORD_W-1:0]   clr_word;

  always_comb begin
    open_word = first_open_word(full);
    free_bit  = first_zero_bit(ram_rdata);
    room      = CNT_W'(17'h10000) - CNT_W'(id_base);
    offset    = CNT_W'(release_id) - CNT_W'(id_base);
    in_range  = (release_id >= id_base) && (offset < CNT_W'(ID_COUNT));
    alloc_idx = {word_addr, free_bit.idx};
    set_word  = ram_rdata | (WORD_W'(1) << free_bit.idx);
    clr_word  = ram_rdata & ~(WORD_W'(1) << bit_sel);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      full  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      full  <= full_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      mode       <= req.mode;
      release_id <= req.release_id;
    end
    word_addr <= word_addr_next;
    bit_sel   <= bit_sel_next;
    limit     <= limit_next;
    rsp       <= rsp_next;
  end

  always_comb begin
    state_next     = state;
    full_next      = full;
    word_addr_next = word_addr;
    bit_sel_next   = bit_sel;
    limit_next     = limit;
    rsp_next       = rsp;
    done_next      = 1'b0;
    ram_req        = '0;
    busy           = (state != S_IDLE);

    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_LOOK;
        end
      end

      S_LOOK: begin
        limit_next = (room < CNT_W'(ID_COUNT)) ? room : CNT_W'(ID_COUNT);
        if (mode == MODE_ALLOC) begin
          if (open_word.found) begin
            word_addr_next = open_word.idx;
            ram_req.rd_en  = 1'b1;
            ram_req.addr   = open_word.idx;
            state_next     = S_MOD;
          end else begin
            rsp_next   = '{granted_id: 16'd0, status: STAT_EXHAUSTED};
            done_next  = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          if (in_range) begin
            word_addr_next = offset[BIT_W +: ADDR_W];
            bit_sel_next   = offset[BIT_W-1:0];
            ram_req.rd_en  = 1'b1;
            ram_req.addr   = offset[BIT_W +: ADDR_W];
            state_next     = S_MOD;
          end else begin
            rsp_next   = '{granted_id: 16'd0, status: STAT_NOT_FOUND};
            done_next  = 1'b1;
            state_next = S_IDLE;
          end
        end
      end

      S_MOD: begin
        // word read in S_LOOK is on ram_rdata now; write back in place
        ram_req.addr = word_addr;
        done_next    = 1'b1;
        state_next   = S_IDLE;
        if (mode == MODE_ALLOC) begin
          // lowest free entry past the nameable range means none is usable
          if (free_bit.found && (CNT_W'(alloc_idx) < limit)) begin
            ram_req.wr_en        = 1'b1;
            ram_req.wdata        = set_word;
            full_next[word_addr] = &set_word;
            rsp_next = '{granted_id: id_base + 16'(alloc_idx), status: STAT_OK};
          end else begin
            rsp_next = '{granted_id: 16'd0, status: STAT_EXHAUSTED};
          end
        end else begin
          ram_req.wr_en        = 1'b1;
          ram_req.wdata        = clr_word;
          full_next[word_addr] = 1'b0;
          rsp_next = '{granted_id: 16'd0, status: STAT_OK};
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
